/* hdl/assert_macros.svh */
// Assertion macros used by the RTL file that checks its own logic (the codec core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/krlc_pkg.sv */
// Types and constants shared by the key run-length codec modules.
`default_nettype none
package krlc_pkg;

  localparam int DATA_W = 16;
  localparam int KEY_W  = 10;
  localparam int LEN_W  = 6;   // length-minus-one field of a run word
  localparam int CNT_W  = 7;   // run frame count, holds up to 64

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_ENC_SECOND,
    ST_DEC_RUN
  } state_t;

  typedef enum logic [1:0] {
    SEL_ENC,
    SEL_PEND,
    SEL_DEC_FIRST,
    SEL_DEC_NEXT
  } out_sel_t;

  typedef struct packed {
    logic     accept;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic out_free;
    logic enc_flush;
    logic enc_close;
    logic dec_multi;
    logic dec_final;
    logic run_open;
  } stat_t;

endpackage
`default_nettype wire

/* hdl/krlc_datapath.sv */
// Datapath: mode register, open run, held word and the output register.
`default_nettype none
module krlc_datapath import krlc_pkg::*; #(
  parameter int RUN_LIMIT = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              codec_mode_wr_en,
  input  wire logic              codec_mode_wr_data,
  input  wire logic [DATA_W-1:0] data_in,
  input  wire logic              last_in,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic      [DATA_W-1:0] data_out,
  output logic                   last_out,
  input  wire cmd_t              cmd,
  output stat_t                  stat
);

  logic             mode;
  logic [KEY_W-1:0] open_key;
  logic [CNT_W-1:0] open_length;
  logic             run_open;
  logic [KEY_W-1:0] pend_key;
  logic             pend_last;
  logic [LEN_W-1:0] rem_cnt;

  logic [KEY_W-1:0] key_in;
  logic [LEN_W-1:0] len_in;
  logic             same_key;
  logic [CNT_W-1:0] new_len;
  logic [CNT_W-1:0] old_len_m1;
  logic [CNT_W-1:0] new_len_m1;
  logic [DATA_W-1:0] out_word_next;
  logic              out_last_next;

  // Field split and encode run tracking
  assign key_in     = data_in[KEY_W-1:0];
  assign len_in     = data_in[DATA_W-1:KEY_W];
  assign same_key   = run_open && (key_in == open_key);
  assign new_len    = same_key ? open_length + CNT_W'(1) : CNT_W'(1);
  assign old_len_m1 = open_length - CNT_W'(1);
  assign new_len_m1 = new_len - CNT_W'(1);

  assign stat.mode      = mode;
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.enc_flush = run_open && !same_key;
  assign stat.enc_close = last_in || (new_len >= CNT_W'(RUN_LIMIT));
  assign stat.dec_multi = (len_in != '0);
  assign stat.dec_final = (rem_cnt == LEN_W'(1));
  assign stat.run_open  = run_open;

  // Result word selection
  always_comb begin
    case (cmd.out_sel)
      SEL_ENC: begin
        if (stat.enc_flush) begin
          out_word_next = {old_len_m1[LEN_W-1:0], open_key};
          out_last_next = 1'b0;
        end else begin
          out_word_next = {new_len_m1[LEN_W-1:0], key_in};
          out_last_next = last_in;
        end
      end
      SEL_PEND: begin
        out_word_next = {{LEN_W{1'b0}}, pend_key};
        out_last_next = pend_last;
      end
      SEL_DEC_FIRST: begin
        out_word_next = {{LEN_W{1'b0}}, key_in};
        out_last_next = last_in && (len_in == '0);
      end
      SEL_DEC_NEXT: begin
        out_word_next = {{LEN_W{1'b0}}, pend_key};
        out_last_next = pend_last && stat.dec_final;
      end
      default: begin
        out_word_next = '0;
        out_last_next = 1'b0;
      end
    endcase
  end

  // Mode register and open run
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_ENCODE;
      open_key    <= '0;
      open_length <= '0;
      run_open    <= 1'b0;
    end else if (codec_mode_wr_en) begin
      mode        <= codec_mode_wr_data;
      open_key    <= '0;
      open_length <= '0;
      run_open    <= 1'b0;
    end else if (cmd.accept && (mode == MODE_ENCODE)) begin
      if (stat.enc_close) begin
        open_key    <= '0;
        open_length <= '0;
        run_open    <= 1'b0;
      end else begin
        open_key    <= key_in;
        open_length <= new_len;
        run_open    <= 1'b1;
      end
    end
  end

  // Held key for the second encode word or the decode expansion
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_key  <= key_in;
      pend_last <= last_in;
      rem_cnt   <= len_in;
    end else if (cmd.out_load && (cmd.out_sel == SEL_DEC_NEXT)) begin
      rem_cnt <= rem_cnt - LEN_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      data_out <= out_word_next;
      last_out <= out_last_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/krlc_ctrl.sv */
// Controller: sequences input acceptance and result words.
`default_nettype none
module krlc_ctrl import krlc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_ACCEPT: begin
        if (accept) begin
          if (stat.mode == MODE_DECODE) begin
            if (stat.dec_multi) state_next = ST_DEC_RUN;
          end else if (stat.enc_flush && stat.enc_close) begin
            state_next = ST_ENC_SECOND;
          end
        end
      end
      ST_ENC_SECOND: begin
        if (stat.out_free) state_next = ST_ACCEPT;
      end
      ST_DEC_RUN: begin
        if (stat.out_free && stat.dec_final) state_next = ST_ACCEPT;
      end
      default: state_next = ST_ACCEPT;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.out_load = 1'b0;
    cmd.out_sel  = SEL_ENC;
    case (state)
      ST_ACCEPT: begin
        in_ready   = stat.out_free;
        cmd.accept = in_valid && stat.out_free;
        if (stat.mode == MODE_DECODE) begin
          cmd.out_sel  = SEL_DEC_FIRST;
          cmd.out_load = cmd.accept;
        end else begin
          cmd.out_sel  = SEL_ENC;
          cmd.out_load = cmd.accept && (stat.enc_flush || stat.enc_close);
        end
      end
      ST_ENC_SECOND: begin
        cmd.out_sel  = SEL_PEND;
        cmd.out_load = stat.out_free;
      end
      ST_DEC_RUN: begin
        cmd.out_sel  = SEL_DEC_NEXT;
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd.out_load = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/key_run_length_codec_core.sv */
// Encode: a taken key word that closes or flushes a run puts that run word out the next cycle.
// A key change that also closes the run holds the input in ST_ENC_SECOND until its second word is loaded.
// Decode: a run word of length L gives L keys, one key per cycle while out_ready holds, out of the
// single output register; the next run word is taken after its last key.
// Synchronous reset selects encode mode, drops any open run, empties output.
`default_nettype none
`include "assert_macros.svh"
module key_run_length_codec_core import krlc_pkg::*; #(
  parameter int RUN_LIMIT = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              codec_mode_wr_en,
  input  wire logic              codec_mode_wr_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [DATA_W-1:0] data_in,
  input  wire logic              last_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [DATA_W-1:0] data_out,
  output logic                   last_out
);

  cmd_t  cmd;
  stat_t stat;

  krlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  krlc_datapath #(
    .RUN_LIMIT (RUN_LIMIT)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .codec_mode_wr_en   (codec_mode_wr_en),
    .codec_mode_wr_data (codec_mode_wr_data),
    .data_in            (data_in),
    .last_in            (last_in),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .data_out           (data_out),
    .last_out           (last_out),
    .cmd                (cmd),
    .stat               (stat)
  );

  // Output register is only loaded when its word has left or is leaving
  `ASSERT_ALWAYS(a_load_free, cmd.out_load |-> (!out_valid || out_ready), "load into busy output")
  // Every accepted run word gives at least its first key
  `ASSERT_CLK(a_dec_emits, (in_valid && in_ready && stat.mode) |-> cmd.out_load, "decode word lost")
  // A last key closes the open run
  `ASSERT_CLK(a_last_closes, (in_valid && in_ready && !stat.mode && last_in) |=> !stat.run_open, "run left open")

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the key run-length codec core: encode and decode modes.
`timescale 1ns / 1ps

module testbench import krlc_pkg::*; ();

  localparam int RUN_LIMIT       = 64;
  localparam int SETTLE_CYCLES   = 6;
  localparam int WATCHDOG_CYCLES = 3000;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              last;
  } codec_word_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              codec_mode_wr_en;
  logic              codec_mode_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [DATA_W-1:0] data_in;
  logic              last_in;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] data_out;
  logic              last_out;

  // words the codec still owes us, oldest first
  codec_word_t due_words[$];
  codec_word_t head;

  // shadow of the codec state
  logic               mode_now = MODE_ENCODE;
  logic [KEY_W-1:0]   run_key  = '0;
  logic [CNT_W-1:0]   run_len  = '0;
  logic               run_live = 1'b0;

  bit quiet = 1'b0;
  int fault_count   = 0;
  int enc_keys      = 0;
  int dec_words     = 0;
  int words_checked = 0;
  int mode_writes   = 0;
  int idle_cycles   = 0;

  key_run_length_codec_core #(.RUN_LIMIT(RUN_LIMIT)) dut (
    .clk                (clk),
    .rst                (rst),
    .codec_mode_wr_en   (codec_mode_wr_en),
    .codec_mode_wr_data (codec_mode_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .data_in            (data_in),
    .last_in            (last_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .data_out           (data_out),
    .last_out           (last_out)
  );

  always #10 clk = ~clk;

  // Packed run word of the open run
  function automatic logic [DATA_W-1:0] open_run_word();
    logic [CNT_W-1:0] len_m1;
    len_m1 = run_len - 1'b1;
    return {len_m1[LEN_W-1:0], run_key};
  endfunction

  function automatic void drop_run();
    run_key  = '0;
    run_len  = '0;
    run_live = 1'b0;
  endfunction

  // Work out the words one accepted input word causes
  function automatic void predict_words(input logic [DATA_W-1:0] word, input logic fin);
    logic [KEY_W-1:0] key;
    int reps;
    int i;
    key = word[KEY_W-1:0];
    if (mode_now == MODE_DECODE) begin
      reps = int'(word[DATA_W-1:KEY_W]) + 1;
      for (i = 0; i < reps; i++)
        due_words.push_back('{{{(DATA_W-KEY_W){1'b0}}, key}, fin && (i == reps - 1)});
    end else begin
      if (run_live && key == run_key) begin
        run_len++;
      end else begin
        if (run_live) due_words.push_back('{open_run_word(), 1'b0});
        run_key  = key;
        run_len  = CNT_W'(1);
        run_live = 1'b1;
      end
      if (fin || run_len >= RUN_LIMIT) begin
        due_words.push_back('{open_run_word(), fin});
        drop_run();
      end
    end
  endfunction

  // Predict on every accepted input word, check every accepted output word
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (mode_now == MODE_DECODE) dec_words++;
        else enc_keys++;
        predict_words(data_in, last_in);
      end
      if (out_valid && out_ready) begin
        words_checked++;
        if (due_words.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected word: data_out=%h last_out=%b", $time, data_out, last_out);
        end else begin
          head = due_words.pop_front();
          if (data_out !== head.data) begin
            fault_count++;
            $display("%0t: data_out expected %h actual %h", $time, head.data, data_out);
          end
          if (last_out !== head.last) begin
            fault_count++;
            $display("%0t: last_out expected %b actual %b", $time, head.last, last_out);
          end
        end
      end
    end
  end

  // Watchdog: no handshake on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_CYCLES) begin
        $display("%0t: no word moved for %0d cycles, %0d still due",
                 $time, WATCHDOG_CYCLES, due_words.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts unless quiet
  initial begin : rx_pacing
    int burst;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Send one word; returns at the edge that accepts it, valid still high
  task automatic send_word(input logic [DATA_W-1:0] word, input logic fin);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_in  <= word;
    last_in  <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every due word, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mode write while idle; any write drops the open run
  task automatic set_mode(input logic mode);
    wait_drained();
    codec_mode_wr_en   <= 1'b1;
    codec_mode_wr_data <= mode;
    mode_now = mode;
    drop_run();
    mode_writes++;
    @(posedge clk);
    codec_mode_wr_en <= 1'b0;
  endtask

  // Runs of random keys with junk in the upper bits; mostly a closed stream
  task automatic encode_burst(input int count);
    int done;
    int span;
    int k;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] junk;
    logic fin_stream;
    done = 0;
    fin_stream = ($urandom_range(0, 3) != 0);
    while (done < count) begin
      key = KEY_W'($urandom);
      case ($urandom_range(0, 9))
        7, 8:    span = $urandom_range(7, 30);
        9:       span = $urandom_range(60, 70);
        default: span = $urandom_range(1, 6);
      endcase
      k = 0;
      while (k < span && done < count) begin
        k++;
        done++;
        junk = LEN_W'($urandom);
        send_word({junk, key},
                  (done == count) ? fin_stream : ($urandom_range(0, 29) == 0));
      end
    end
  endtask

  // Run words, mostly short, now and then full range
  task automatic decode_burst(input int count);
    int i;
    logic [LEN_W-1:0] len_m1;
    logic [KEY_W-1:0] key;
    for (i = 0; i < count; i++) begin
      len_m1 = LEN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 5));
      key = KEY_W'($urandom);
      send_word({len_m1, key},
                (i == count - 1) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 9) == 0));
    end
  endtask

  // Encode edge cases after reset
  task automatic test_encode_basics();
    send_word(16'h0000, 1'b1);   // single frame stream
    send_word(16'hFFFF, 1'b0);   // key 3FF, upper bits ignored
    send_word(16'h03FF, 1'b0);
    send_word(16'hAFFF, 1'b0);
    send_word(16'h0155, 1'b0);   // key change closes a run of three
    send_word(16'h5555, 1'b1);   // same key with junk bits, last
    send_word(16'h02AA, 1'b0);
    send_word(16'h0001, 1'b1);   // key change and last in one word: two results
    send_word(16'h0200, 1'b0);
    send_word(16'h0200, 1'b0);
    send_word(16'h0200, 1'b1);
    wait_drained();
  endtask

  // Mode writes drop the open run without emitting it
  task automatic test_mode_writes();
    send_word(16'h0123, 1'b0);
    send_word(16'h0123, 1'b0);
    set_mode(MODE_ENCODE);       // same mode, run still dropped
    send_word(16'h0123, 1'b1);
    send_word(16'h0321, 1'b0);
    set_mode(MODE_DECODE);
    set_mode(MODE_DECODE);
  endtask

  // Decode extremes of length and key
  task automatic test_decode_basics();
    send_word(16'h0000, 1'b0);   // one key of zero
    send_word(16'hFFFF, 1'b1);   // 64 keys, final one marked
    send_word(16'h03FF, 1'b1);
    send_word(16'hFC00, 1'b0);   // 64 zero keys, no mark
    send_word(16'h0555, 1'b0);
    send_word(16'h5AAA, 1'b1);
    wait_drained();
  endtask

  // Long runs: split at the limit, and fill together with last
  task automatic test_run_split();
    int i;
    set_mode(MODE_ENCODE);
    for (i = 0; i < RUN_LIMIT + 5; i++) send_word(16'h00F0, 1'b0);
    send_word(16'h030F, 1'b0);
    for (i = 1; i < RUN_LIMIT; i++) send_word(16'h030F, 1'b0);
    send_word(16'h030F, 1'b0);
    for (i = 1; i < RUN_LIMIT; i++) send_word(16'h0066, 1'b0);
    send_word(16'h0066, 1'b1);
    wait_drained();
  endtask

  // Random phases in both modes, with stalls and a mid-stream hold-off
  task automatic test_random_traffic();
    int sent;
    int batch;
    logic mode;
    sent = 0;
    while (sent < 50) begin
      mode  = 1'($urandom_range(0, 1));
      quiet = ($urandom_range(0, 3) == 0);
      set_mode(mode);
      batch = (mode == MODE_DECODE) ? $urandom_range(8, 30) : $urandom_range(20, 50);
      if (mode == MODE_DECODE) decode_burst(batch);
      else encode_burst(batch);
      sent += batch;
      if (sent == batch || $urandom_range(0, 2) == 0) begin
        wait_drained();
        if (mode == MODE_DECODE) decode_burst(10);
        else encode_burst(10);
        sent += 10;
      end
    end
    quiet = 1'b0;
  endtask

  // Back-to-back traffic with no stalls to close the run
  task automatic test_steady_stream();
    quiet = 1'b1;
    set_mode(MODE_ENCODE);
    encode_burst(20);
    set_mode(MODE_DECODE);
    decode_burst(10);
    wait_drained();
  endtask

  initial begin : stimulus
    rst                <= 1'b1;
    codec_mode_wr_en   <= 1'b0;
    codec_mode_wr_data <= 1'b0;
    in_valid           <= 1'b0;
    data_in            <= '0;
    last_in            <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_encode_basics();
    test_mode_writes();
    test_decode_basics();
    test_run_split();
    test_random_traffic();
    test_steady_stream();

    $display("Run covered %0d keys encoded and %0d run words decoded, %0d results checked,",
             enc_keys, dec_words, words_checked);
    $display("across %0d mode writes, split runs and stalls on both sides.", mode_writes);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
